@@ rtl/gbn_pkg.sv @@
`default_nettype none

package gbn_pkg;

	// Largest payload a clean packet may declare
	localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

	// Reset value of the drop limit register
	localparam logic [15:0] DROP_LIMIT_RST = 16'd500;

	// Saturation value of the consecutive drop counter
	localparam logic [16:0] DROP_SAT = 17'h1FFFF;

	// Depth of the packet queue between front and back
	localparam int PQ_DEPTH = 4;
	localparam int PQ_AW    = $clog2(PQ_DEPTH);

	// Depth of the result queue at the output
	localparam int RQ_DEPTH = 2;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	// Verdict codes
	localparam logic [2:0] V_ACCEPT   = 3'd0;
	localparam logic [2:0] V_COMPLETE = 3'd1;
	localparam logic [2:0] V_CORRUPT  = 3'd2;
	localparam logic [2:0] V_OUTSEQ   = 3'd3;
	localparam logic [2:0] V_ABORT    = 3'd4;
	localparam logic [2:0] V_IGNORED  = 3'd5;

	// Packet summary handed from the front to the back
	typedef struct packed {
		logic [31:0] end_offset;
		logic [15:0] length;
		logic [31:0] size;
		logic        bad;
	} pkt_t;

	// Status of the packet queue
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// One result transaction
	typedef struct packed {
		logic [2:0]  verdict;
		logic [31:0] ack_number;
		logic [31:0] ack_check;
		logic [31:0] bytes_received;
		logic [16:0] drop_run;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/gbn_front.sv @@
`default_nettype none

module gbn_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic             mode,
	input  wire logic [31:0]      end_offset,
	input  wire logic [31:0]      ack_field,
	input  wire logic [15:0]      payload_length,
	input  wire logic [31:0]      total_size,
	input  wire logic [31:0]      sent_checksum,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_item,
	output logic                  pkt_push,
	output gbn_pkg::pkt_t         pkt
);

	logic [31:0] sum_q;
	logic [31:0] end_q;
	logic [15:0] len_q;
	logic [31:0] size_q;

	logic        hdr;
	logic [31:0] sum_nxt;
	logic [31:0] end_nxt;
	logic [15:0] len_nxt;
	logic [31:0] size_nxt;

	// Fold the sent checksum into the sum at the header, add bytes sign-extended
	always_comb begin
		hdr      = (mode == 1'b0);
		end_nxt  = hdr ? end_offset : end_q;
		len_nxt  = hdr ? payload_length : len_q;
		size_nxt = hdr ? total_size : size_q;
		if (hdr) begin
			sum_nxt = end_offset + ack_field + total_size + sent_checksum;
		end else begin
			sum_nxt = sum_q + {{24{data_byte[7]}}, data_byte};
		end
	end

	// Hold the packet context across its items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			end_q  <= '0;
			len_q  <= '0;
			size_q <= '0;
		end else if (accept) begin
			sum_q  <= sum_nxt;
			end_q  <= end_nxt;
			len_q  <= len_nxt;
			size_q <= size_nxt;
		end
	end

	// Classify the packet on its last item
	assign pkt_push       = accept && last_item;
	assign pkt.end_offset = end_nxt;
	assign pkt.length     = len_nxt;
	assign pkt.size       = size_nxt;
	assign pkt.bad        = (len_nxt > gbn_pkg::MAX_PAYLOAD) || (sum_nxt != 32'd0);

endmodule

`default_nettype wire

@@ rtl/gbn_pktq.sv @@
`default_nettype none

module gbn_pktq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire gbn_pkg::pkt_t    wdata,
	input  wire logic             pop,
	output gbn_pkg::pkt_t         rdata,
	output gbn_pkg::q_status_t    status
);

	gbn_pkg::pkt_t                 mem_q [gbn_pkg::PQ_DEPTH];
	logic [gbn_pkg::PQ_AW-1:0]     wr_ptr_q;
	logic [gbn_pkg::PQ_AW-1:0]     rd_ptr_q;
	logic [gbn_pkg::PQ_AW:0]       count_q;

	assign status.full  = (count_q == (gbn_pkg::PQ_AW+1)'(gbn_pkg::PQ_DEPTH));
	assign status.empty = (count_q == '0);
	assign rdata        = mem_q[rd_ptr_q];

	// Store a packet summary
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/gbn_back.sv @@
`default_nettype none

module gbn_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             drop_limit_we,
	input  wire logic [15:0]      drop_limit,
	input  wire gbn_pkg::pkt_t    pkt,
	input  wire gbn_pkg::q_status_t pq_status,
	output logic                  pkt_pop,
	input  wire logic             pop,
	output logic                  empty,
	output gbn_pkg::res_t         res
);

	logic [15:0]               limit_q;
	logic [31:0]               total_q;
	logic [16:0]               drops_q;
	logic                      finished_q;

	gbn_pkg::res_t             rq_q [gbn_pkg::RQ_DEPTH];
	logic [gbn_pkg::RQ_AW-1:0] rq_wr_q;
	logic [gbn_pkg::RQ_AW-1:0] rq_rd_q;
	logic [gbn_pkg::RQ_AW:0]   rq_cnt_q;

	logic                      rq_full;
	logic                      rq_pop;
	logic [16:0]               drops_inc;
	logic                      abort;
	logic [31:0]               total_sum;
	logic                      in_seq;
	logic [31:0]               total_nxt;
	logic [16:0]               drops_nxt;
	logic                      finished_nxt;
	gbn_pkg::res_t             res_nxt;

	assign rq_full = (rq_cnt_q == (gbn_pkg::RQ_AW+1)'(gbn_pkg::RQ_DEPTH));
	assign empty   = (rq_cnt_q == '0);
	assign rq_pop  = pop && !empty;
	assign pkt_pop = !pq_status.empty && !rq_full;
	assign res     = rq_q[rq_rd_q];

	// Judge the packet at the head of the queue
	always_comb begin
		drops_inc    = (drops_q == gbn_pkg::DROP_SAT) ? drops_q : drops_q + 17'd1;
		abort        = (drops_inc > {1'b0, limit_q});
		total_sum    = total_q + {16'd0, pkt.length};
		in_seq       = (total_sum == pkt.end_offset);
		total_nxt    = total_q;
		drops_nxt    = drops_q;
		finished_nxt = finished_q;
		res_nxt.verdict    = gbn_pkg::V_IGNORED;
		res_nxt.ack_number = '0;
		priority if (finished_q) begin
			res_nxt.verdict = gbn_pkg::V_IGNORED;
		end else if (pkt.bad || !in_seq) begin
			drops_nxt       = drops_inc;
			finished_nxt    = abort;
			res_nxt.verdict = abort ? gbn_pkg::V_ABORT :
				(pkt.bad ? gbn_pkg::V_CORRUPT : gbn_pkg::V_OUTSEQ);
		end else begin
			total_nxt          = total_sum;
			drops_nxt          = '0;
			finished_nxt       = (total_sum >= pkt.size);
			res_nxt.verdict    = (total_sum >= pkt.size) ? gbn_pkg::V_COMPLETE :
				gbn_pkg::V_ACCEPT;
			res_nxt.ack_number = pkt.end_offset;
		end
		res_nxt.ack_check      = 32'd0 - res_nxt.ack_number;
		res_nxt.bytes_received = total_nxt;
		res_nxt.drop_run       = drops_nxt;
	end

	// Hold the transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= gbn_pkg::DROP_LIMIT_RST;
			total_q    <= '0;
			drops_q    <= '0;
			finished_q <= 1'b0;
		end else begin
			if (drop_limit_we) begin
				limit_q <= drop_limit;
			end
			if (pkt_pop) begin
				total_q    <= total_nxt;
				drops_q    <= drops_nxt;
				finished_q <= finished_nxt;
			end
		end
	end

	// Store results for the consumer
	always_ff @(posedge clk) begin
		if (pkt_pop) begin
			rq_q[rq_wr_q] <= res_nxt;
		end
	end

	// Advance result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (pkt_pop) begin
				rq_wr_q <= rq_wr_q + 1'b1;
			end
			if (rq_pop) begin
				rq_rd_q <= rq_rd_q + 1'b1;
			end
			if (pkt_pop && !rq_pop) begin
				rq_cnt_q <= rq_cnt_q + 1'b1;
			end else if (rq_pop && !pkt_pop) begin
				rq_cnt_q <= rq_cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/gbn_receiver_checker_top.sv @@
// Go-Back-N receiver verdict engine.
// Input channel: push/full. Each packet is one header item (mode 0) and then
// its payload bytes (mode 1); the item with last_item high closes the packet.
// Result channel: empty/pop. One result transaction per closed packet with
// verdict, ack_number, ack_check, bytes_received and drop_run.
// Configuration: drop_limit is written when drop_limit_we is high.
// Throughput: one item per cycle on the input while full is low; one verdict
// per cycle at the back while a packet waits and the result queue has room;
// the sequence add and compare there are combinational. A result shows on
// the ports once its packet summary has been written into the packet queue
// and then judged from there into the result queue.
// The front classifies packets into a 4-entry packet queue; the back judges
// them into a 2-entry result queue. When the consumer stalls, the result
// queue fills, the back stops, the packet queue fills and full rises;
// items that are not the last of a packet are also held off then.
// Reset clears all queues and the transfer state and sets drop_limit to 500.
// After completion or abort, every closed packet gets the ignored verdict.
`default_nettype none

module gbn_receiver_checker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        drop_limit_we,
	input  wire logic [15:0] drop_limit,
	input  wire logic        push,
	output logic             full,
	input  wire logic        mode,
	input  wire logic [31:0] end_offset,
	input  wire logic [31:0] ack_field,
	input  wire logic [15:0] payload_length,
	input  wire logic [31:0] total_size,
	input  wire logic [31:0] sent_checksum,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_item,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       verdict,
	output logic [31:0]      ack_number,
	output logic [31:0]      ack_check,
	output logic [31:0]      bytes_received,
	output logic [16:0]      drop_run
);

	logic               accept;
	logic               pkt_push;
	logic               pkt_pop;
	gbn_pkg::pkt_t      pkt_in;
	gbn_pkg::pkt_t      pkt_out;
	gbn_pkg::q_status_t pq_status;
	gbn_pkg::res_t      res;

	assign full   = pq_status.full;
	assign accept = push && !full;

	gbn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.mode           (mode),
		.end_offset     (end_offset),
		.ack_field      (ack_field),
		.payload_length (payload_length),
		.total_size     (total_size),
		.sent_checksum  (sent_checksum),
		.data_byte      (data_byte),
		.last_item      (last_item),
		.pkt_push       (pkt_push),
		.pkt            (pkt_in)
	);

	gbn_pktq u_pktq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (pkt_push),
		.wdata  (pkt_in),
		.pop    (pkt_pop),
		.rdata  (pkt_out),
		.status (pq_status)
	);

	gbn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.drop_limit_we (drop_limit_we),
		.drop_limit    (drop_limit),
		.pkt           (pkt_out),
		.pq_status     (pq_status),
		.pkt_pop       (pkt_pop),
		.pop           (pop),
		.empty         (empty),
		.res           (res)
	);

	assign verdict        = res.verdict;
	assign ack_number     = res.ack_number;
	assign ack_check      = res.ack_check;
	assign bytes_received = res.bytes_received;
	assign drop_run       = res.drop_run;

endmodule

`default_nettype wire

@@ rtl/gbn_checker.sv @@
`default_nettype none

module gbn_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [2:0]  verdict,
	input  wire logic [31:0] ack_number,
	input  wire logic [31:0] ack_check,
	input  wire logic [16:0] drop_run
);

	// Hold a waiting result until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(verdict) && $stable(ack_number)))
		else $error("result changed while waiting");

	// Ack check word is the negated ack
	a_ack_check: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (ack_check == 32'd0 - ack_number))
		else $error("ack check mismatch");

	// Only accepted packets carry an ack
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && verdict != gbn_pkg::V_ACCEPT && verdict != gbn_pkg::V_COMPLETE)
		|-> (ack_number == 32'd0))
		else $error("ack on a rejected packet");

	// Accept clears the drop run
	a_drop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (verdict == gbn_pkg::V_ACCEPT || verdict == gbn_pkg::V_COMPLETE))
		|-> (drop_run == 17'd0))
		else $error("drop run not cleared on accept");

	// Drop verdicts carry a nonzero drop run
	a_drop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (verdict == gbn_pkg::V_CORRUPT || verdict == gbn_pkg::V_OUTSEQ
			|| verdict == gbn_pkg::V_ABORT)) |-> (drop_run != 17'd0))
		else $error("drop verdict with zero drop run");

endmodule

bind gbn_receiver_checker_top gbn_checker u_gbn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.verdict    (verdict),
	.ack_number (ack_number),
	.ack_check  (ack_check),
	.drop_run   (drop_run)
);

`default_nettype wire

@@ bench/gbn_receiver_checker_top_tb.sv @@
`timescale 1ns / 1ps

module gbn_receiver_checker_top_tb;

	localparam logic MODE_HEADER = 1'b0;
	localparam logic MODE_BYTE   = 1'b1;
	localparam int   SETTLE      = 12;
	localparam int   TIMEOUT_NS  = 5_000_000;

	// One input transaction, field for field as on the ports
	typedef struct packed {
		logic        mode;
		logic [31:0] end_offset;
		logic [31:0] ack_field;
		logic [15:0] payload_length;
		logic [31:0] total_size;
		logic [31:0] sent_checksum;
		logic [7:0]  data_byte;
		logic        last_item;
	} item_t;

	// Transfer state as the receiver keeps it, plus its drop limit
	typedef struct packed {
		logic [31:0] received_total;
		logic [31:0] expected_size;
		logic [16:0] drop_count;
		logic [31:0] running_sum;
		logic [31:0] held_end_offset;
		logic [15:0] held_length;
		logic [31:0] held_checksum;
		logic [31:0] held_size;
		logic        finished;
		logic [15:0] limit;
	} xfer_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        drop_limit_we = 1'b0;
	logic [15:0] drop_limit = '0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	item_t       drv = '0;
	logic        full;
	logic        empty;
	logic [2:0]  verdict;
	logic [31:0] ack_number;
	logic [31:0] ack_check;
	logic [31:0] bytes_received;
	logic [16:0] drop_run;

	item_t         pending_items[$];
	gbn_pkg::res_t due_verdicts[$];
	logic [7:0]    payload_buf[$];
	xfer_t         rx_state;
	xfer_t         plan_state;
	gbn_pkg::res_t due;
	gbn_pkg::res_t head;
	int            items_queued = 0;
	int            fail_count = 0;
	int            burst_left = 0;
	int            gap_left = 0;
	logic [9:0]    rx_tick = '0;

	gbn_receiver_checker_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.drop_limit_we (drop_limit_we),
		.drop_limit    (drop_limit),
		.push          (push),
		.full          (full),
		.mode          (drv.mode),
		.end_offset    (drv.end_offset),
		.ack_field     (drv.ack_field),
		.payload_length(drv.payload_length),
		.total_size    (drv.total_size),
		.sent_checksum (drv.sent_checksum),
		.data_byte     (drv.data_byte),
		.last_item     (drv.last_item),
		.empty         (empty),
		.pop           (pop),
		.verdict       (verdict),
		.ack_number    (ack_number),
		.ack_check     (ack_check),
		.bytes_received(bytes_received),
		.drop_run      (drop_run)
	);

	// Advance the transfer state by one item; return 1 when a verdict comes out
	function automatic bit judge_item(inout xfer_t s, input item_t it,
			output gbn_pkg::res_t r);
		logic [31:0] seq_end;
		logic [31:0] chk;
		bit dropped;
		r = '0;
		if (s.finished) begin
			if (!it.last_item)
				return 1'b0;
			r.verdict = gbn_pkg::V_IGNORED;
			r.bytes_received = s.received_total;
			r.drop_run = s.drop_count;
			return 1'b1;
		end
		if (it.mode == MODE_HEADER) begin
			s.held_end_offset = it.end_offset;
			s.held_length = it.payload_length;
			s.held_size = it.total_size;
			s.held_checksum = it.sent_checksum;
			s.running_sum = it.end_offset + it.ack_field + it.total_size;
		end else begin
			s.running_sum = s.running_sum + {{24{it.data_byte[7]}}, it.data_byte};
		end
		if (!it.last_item)
			return 1'b0;
		dropped = 1'b1;
		chk = s.running_sum + s.held_checksum;
		if (s.held_length > gbn_pkg::MAX_PAYLOAD || chk != 32'd0) begin
			r.verdict = gbn_pkg::V_CORRUPT;
		end else begin
			s.expected_size = s.held_size;
			seq_end = s.received_total + {16'd0, s.held_length};
			if (seq_end != s.held_end_offset) begin
				r.verdict = gbn_pkg::V_OUTSEQ;
			end else begin
				dropped = 1'b0;
				s.received_total = seq_end;
				s.drop_count = '0;
				r.verdict = gbn_pkg::V_ACCEPT;
				if (s.received_total >= s.expected_size) begin
					r.verdict = gbn_pkg::V_COMPLETE;
					s.finished = 1'b1;
				end
				r.ack_number = s.held_end_offset;
				r.ack_check = 32'd0 - s.held_end_offset;
			end
		end
		// Count the drop, saturating, and abort past the limit
		if (dropped) begin
			if (s.drop_count != gbn_pkg::DROP_SAT)
				s.drop_count = s.drop_count + 1'b1;
			if (s.drop_count > {1'b0, s.limit}) begin
				s.finished = 1'b1;
				r.verdict = gbn_pkg::V_ABORT;
			end
		end
		r.bytes_received = s.received_total;
		r.drop_run = s.drop_count;
		return 1'b1;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.mode = 1'($urandom_range(1));
		it.end_offset = $urandom;
		it.ack_field = $urandom;
		it.payload_length = 16'($urandom);
		it.total_size = $urandom;
		it.sent_checksum = $urandom;
		it.data_byte = 8'($urandom);
		it.last_item = 1'($urandom_range(1));
		return it;
	endfunction

	// Track the item in the planning copy, then hand it to the driver
	task automatic queue_item(input item_t it);
		gbn_pkg::res_t scratch;
		void'(judge_item(plan_state, it, scratch));
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic fill_payload(input int n);
		repeat (n) payload_buf.push_back(8'($urandom_range(255)));
	endtask

	// Build a header and the bytes in payload_buf; a dirty packet gets a bad checksum
	task automatic queue_packet(input logic [31:0] eoff, input logic [31:0] ackf,
			input logic [15:0] len, input logic [31:0] size, input bit clean);
		item_t it;
		logic [31:0] sum;
		logic [31:0] skew;
		int n;
		n = payload_buf.size();
		sum = eoff + ackf + size;
		foreach (payload_buf[i])
			sum = sum + {{24{payload_buf[i][7]}}, payload_buf[i]};
		skew = $urandom;
		if (skew == 32'd0)
			skew = 32'd1;
		it = random_item();
		it.mode = MODE_HEADER;
		it.end_offset = eoff;
		it.ack_field = ackf;
		it.payload_length = len;
		it.total_size = size;
		it.sent_checksum = clean ? 32'd0 - sum : 32'd0 - sum + skew;
		it.last_item = (n == 0);
		queue_item(it);
		for (int i = 0; i < n; i++) begin
			it = random_item();
			it.mode = MODE_BYTE;
			it.data_byte = payload_buf[i];
			it.last_item = (i == n - 1);
			queue_item(it);
		end
		payload_buf.delete();
	endtask

	// Pick a declared length and fill the payload, mostly short and matching
	task automatic pick_shape(output logic [15:0] len);
		int r;
		r = $urandom_range(9);
		if (r < 7) begin
			len = 16'($urandom_range(12));
			fill_payload(int'(len));
		end else if (r == 7) begin
			len = 16'($urandom_range(13, gbn_pkg::MAX_PAYLOAD));
			fill_payload($urandom_range(6));
		end else if (r == 8) begin
			len = gbn_pkg::MAX_PAYLOAD;
			fill_payload($urandom_range(3));
		end else begin
			len = 16'($urandom_range(12));
			fill_payload($urandom_range(12));
		end
	endtask

	// In-order clean packet whose size stays out of reach
	task automatic good_packet();
		logic [15:0] len;
		pick_shape(len);
		queue_packet(plan_state.received_total + len, $urandom, len,
			$urandom | 32'h8000_0000, 1'b1);
	endtask

	task automatic run_random(input int n);
		int stop;
		int k;
		item_t it;
		logic [15:0] len;
		logic [31:0] skew;
		stop = items_queued + n;
		while (items_queued < stop) begin
			k = $urandom_range(99);
			// Hold back anything that can drop once the run is at the limit
			if (plan_state.drop_count >= {1'b0, plan_state.limit})
				k = 0;
			if (k < 55) begin
				good_packet();
			end else if (k < 68) begin
				pick_shape(len);
				queue_packet(plan_state.received_total + len, $urandom, len, $urandom, 1'b0);
			end else if (k < 73) begin
				fill_payload($urandom_range(4));
				len = 16'($urandom_range(gbn_pkg::MAX_PAYLOAD + 1, 65535));
				queue_packet(plan_state.received_total + len, $urandom, len, $urandom, 1'b1);
			end else if (k < 83) begin
				pick_shape(len);
				skew = $urandom;
				if (skew == 32'd0)
					skew = 32'd1;
				queue_packet(plan_state.received_total + len + skew, $urandom, len,
					$urandom, 1'b1);
			end else if (k < 90) begin
				// Header that a second header cuts short
				it = random_item();
				it.mode = MODE_HEADER;
				it.last_item = 1'b0;
				queue_item(it);
				repeat ($urandom_range(2)) begin
					it = random_item();
					it.mode = MODE_BYTE;
					it.last_item = 1'b0;
					queue_item(it);
				end
				good_packet();
			end else if (k < 95) begin
				// Bytes with no header of their own
				for (int i = $urandom_range(1, 3); i > 0; i--) begin
					it = random_item();
					it.mode = MODE_BYTE;
					it.last_item = (i == 1);
					queue_item(it);
				end
			end else begin
				queue_item(random_item());
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || push || due_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_drop_limit(input logic [15:0] v);
		wait_drained();
		drop_limit <= v;
		drop_limit_we <= 1'b1;
		@(posedge clk);
		drop_limit_we <= 1'b0;
		rx_state.limit = v;
		plan_state.limit = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// Drive input transactions in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			drv <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (push && !full) begin
				if (judge_item(rx_state, drv, due))
					due_verdicts.push_back(due);
			end
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					push <= 1'b0;
				end else if (pending_items.size() != 0) begin
					drv <= pending_items.pop_front();
					push <= 1'b1;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Check result transactions against the oldest due verdict; stall on a rotating pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_tick <= '0;
		end else begin
			if (pop && !empty) begin
				if (due_verdicts.size() == 0) begin
					$error("result transaction with none due, verdict %0d", verdict);
					fail_count++;
				end else begin
					head = due_verdicts.pop_front();
					if (verdict !== head.verdict) begin
						$error("verdict: expected %0d, got %0d", head.verdict, verdict);
						fail_count++;
					end
					if (ack_number !== head.ack_number) begin
						$error("ack_number: expected %h, got %h", head.ack_number, ack_number);
						fail_count++;
					end
					if (ack_check !== head.ack_check) begin
						$error("ack_check: expected %h, got %h", head.ack_check, ack_check);
						fail_count++;
					end
					if (bytes_received !== head.bytes_received) begin
						$error("bytes_received: expected %0d, got %0d", head.bytes_received,
							bytes_received);
						fail_count++;
					end
					if (drop_run !== head.drop_run) begin
						$error("drop_run: expected %0d, got %0d", head.drop_run, drop_run);
						fail_count++;
					end
				end
			end
			rx_tick <= rx_tick + 1'b1;
			unique case (rx_tick[9:8])
				2'd0: pop <= 1'b1;
				2'd1: pop <= ($urandom_range(3) != 0);
				2'd2: pop <= (rx_tick[4:0] < 5'd6);
				default: pop <= rx_tick[1];
			endcase
		end
	end

	initial begin
		item_t it;
		logic [15:0] len;
		rx_state = '0;
		rx_state.limit = gbn_pkg::DROP_LIMIT_RST;
		plan_state = rx_state;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes before any header sum onto the zeroed held words
		it = random_item();
		it.mode = MODE_BYTE;
		it.data_byte = 8'h80;
		it.last_item = 1'b1;
		queue_item(it);
		// Header alone closes the packet; checksum word of zero
		queue_packet(32'd0, 32'd1, 16'd0, 32'hFFFF_FFFF, 1'b1);
		// Largest clean length, fewer bytes than declared, sign extremes
		payload_buf = '{8'hFF, 8'h7F, 8'h00, 8'h80};
		queue_packet(plan_state.received_total + gbn_pkg::MAX_PAYLOAD, 32'hFFFF_FFFF,
			gbn_pkg::MAX_PAYLOAD, 32'hFFFF_FFFF, 1'b1);
		// Lengths past the payload limit
		fill_payload(1);
		queue_packet(plan_state.received_total + gbn_pkg::MAX_PAYLOAD + 1, $urandom,
			16'(gbn_pkg::MAX_PAYLOAD + 1), $urandom, 1'b1);
		fill_payload(1);
		queue_packet(plan_state.received_total + 16'hFFFF, $urandom, 16'hFFFF, $urandom, 1'b1);
		// Bad checksum
		fill_payload(3);
		queue_packet(plan_state.received_total + 3, $urandom, 16'd3, $urandom, 1'b0);
		// Clean but out of sequence, zero size and all-ones offset
		fill_payload(2);
		queue_packet(plan_state.received_total + 3, $urandom, 16'd2, 32'd0, 1'b1);
		fill_payload(1);
		queue_packet(32'hFFFF_FFFF, $urandom, 16'd4, $urandom, 1'b1);
		// Header cut short by a new header that closes with a nonzero length
		it = random_item();
		it.mode = MODE_HEADER;
		it.last_item = 1'b0;
		queue_item(it);
		it = random_item();
		it.mode = MODE_BYTE;
		it.last_item = 1'b0;
		queue_item(it);
		queue_packet(plan_state.received_total + 5, $urandom, 16'd5, 32'hC000_0000, 1'b1);
		// Stray zero byte reuses the accepted header and fails the sequence test
		it = random_item();
		it.mode = MODE_BYTE;
		it.data_byte = 8'h00;
		it.last_item = 1'b1;
		queue_item(it);
		// Checksum word of all ones
		queue_packet(plan_state.received_total, 32'd1 - plan_state.received_total - 32'h8000_0000,
			16'd0, 32'h8000_0000, 1'b1);
		// More bytes than declared
		fill_payload(5);
		queue_packet(plan_state.received_total + 2, $urandom, 16'd2, 32'h9000_0000, 1'b1);

		write_drop_limit(16'hFFFF);
		run_random(130);
		// Let every due verdict come back before going on
		wait_drained();
		run_random(130);

		write_drop_limit(16'd3);
		run_random(230);

		write_drop_limit(16'd1);
		run_random(200);

		// Close the transfer, by completion or by abort, then feed ignored items
		write_drop_limit(16'd0);
		repeat (3) good_packet();
		if ($urandom_range(1)) begin
			fill_payload($urandom_range(3));
			len = 16'($urandom_range(1, 12));
			queue_packet(plan_state.received_total + len, $urandom, len,
				plan_state.received_total + len - $urandom_range(1), 1'b1);
		end else begin
			fill_payload(2);
			len = 16'($urandom_range(12));
			queue_packet(plan_state.received_total + len, $urandom, len, $urandom, 1'b0);
		end
		repeat (16) queue_item(random_item());

		wait_drained();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
